[sv/bgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared types and constants of the bilinear grid sampler.
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int VAL_W         = 32;
    localparam int POS_W         = 22;
    localparam int IDX_W         = 6;
    localparam int IN_TDATA_W    = 88;
    localparam int OUT_TDATA_W   = 32;

    localparam int DEF_GRID_ROWS = 64;
    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_FRAC_BITS = 16;

    // Field offsets inside the slave-side tdata word.
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + IDX_W;
    localparam int VAL_LSB   = COL_LSB + IDX_W;
    localparam int POSX_LSB  = VAL_LSB + VAL_W;
    localparam int POSY_LSB  = POSX_LSB + POS_W;

    // Request kinds carried in tuser.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_MUL1,
        S_MUL2,
        S_ADD2,
        S_MUL3,
        S_FIN
    } t_state;

endpackage

[sv/bgs_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_bank
// One bank of the grid store: a write port and a read port with registered
// read data.
// ----------------------------------------------------------------------------
module bgs_bank
    import bgs_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [VAL_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [VAL_W-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bgs_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_blend
// Two-point blend unit: registered products a*(S-f) and b*f, followed by the
// sum, rounding to nearest (ties upward) and the scale-down by S.
// ----------------------------------------------------------------------------
module bgs_blend
    import bgs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    input  logic [FRAC_BITS-1:0]   i_f,
    output logic signed [VAL_W+2:0] o_value
);

    localparam int PROD_W = VAL_W + FRAC_BITS + 2;
    localparam int ACC_W  = PROD_W + 1;

    logic [FRAC_BITS:0]         w_wa;
    logic [FRAC_BITS:0]         w_wb;
    logic signed [PROD_W-1:0]   r_pa;
    logic signed [PROD_W-1:0]   r_pb;
    logic signed [ACC_W-1:0]    w_acc;

    assign w_wa = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_f};
    assign w_wb = {1'b0, i_f};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= i_a * $signed({1'b0, w_wa});
            r_pb <= i_b * $signed({1'b0, w_wb});
        end
    end

    assign w_acc = ACC_W'(r_pa) + ACC_W'(r_pb)
                 + $signed({{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});

    // Taking the upper bits of a signed value is a floor division by S.
    assign o_value = w_acc[ACC_W-1:FRAC_BITS];

endmodule

[sv/bilinear_grid_sample.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_sample
// Grid store with bilinear sampling of signed Q16.16 cell values.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel; tuser selects a cell write (0) or a
// sample (1). A write is stored in its accept cycle and gives no result; the
// next request may follow in the cycle after. A sample reads its four
// neighbours from two row-parity banks, two per cycle in S_RD0 and S_RD1,
// then runs three blends through one shared multiply unit. Its result is
// registered on m_axis at the end of S_FIN, after S_RD0, S_RD1, S_MUL1,
// S_MUL2, S_ADD2 and S_MUL3, and the next request is taken back in S_IDLE,
// so a sample occupies the block until its result is registered. A sample
// whose neighbours leave the grid skips the reads and the blends: zero with
// tuser set is registered at the end of S_FIN, straight after S_RD0.
// Reset clears the sequencer and the output valid; the grid contents are not
// cleared, and a cell must be written before it is sampled.
// The result waits in the output register while m_axis_tready is low; the
// next request is still accepted, and a finished sample waits in its final
// state until the output register is free.
// ----------------------------------------------------------------------------
module bilinear_grid_sample
    import bgs_pkg::*;
#(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_row[5:0], cell_col[11:6], cell_value[43:12], pos_x[65:44], pos_y[87:66]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_value[31:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // out_of_range
    output logic                   m_axis_tuser
);

    localparam int ROW_W  = ($clog2(GRID_ROWS) < 2) ? 2 : $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ADDR_W = ROW_W - 1 + COL_W;
    localparam int INT_W  = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
    localparam int SUM_W  = VAL_W + 3;

    // Operand selections of the shared blend unit.
    localparam logic [1:0] BLEND_ROW_LO = 2'd0;
    localparam logic [1:0] BLEND_ROW_HI = 2'd1;
    localparam logic [1:0] BLEND_FINAL  = 2'd2;

    function automatic logic [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            sat_val = hi[VAL_W-1:0];
        end else if (v < lo) begin
            sat_val = lo[VAL_W-1:0];
        end else begin
            sat_val = v[VAL_W-1:0];
        end
    endfunction

    // Input fields.
    logic [IDX_W-1:0]  w_cell_row;
    logic [IDX_W-1:0]  w_cell_col;
    logic [VAL_W-1:0]  w_cell_value;
    logic [POS_W-1:0]  w_pos_x;
    logic [POS_W-1:0]  w_pos_y;
    logic              w_accept;
    logic              w_wr_ok;

    assign w_cell_row   = s_axis_tdata[ROW_LSB +: IDX_W];
    assign w_cell_col   = s_axis_tdata[COL_LSB +: IDX_W];
    assign w_cell_value = s_axis_tdata[VAL_LSB +: VAL_W];
    assign w_pos_x      = s_axis_tdata[POSX_LSB +: POS_W];
    assign w_pos_y      = s_axis_tdata[POSY_LSB +: POS_W];
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_wr_ok      = (32'(w_cell_row) < 32'(GRID_ROWS))
                       && (32'(w_cell_col) < 32'(GRID_COLS));

    // Sample registers.
    t_state               r_state, n_state;
    logic [INT_W-1:0]     r_xi;
    logic [INT_W-1:0]     r_yi;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;
    logic [VAL_W-1:0]     r_c0_lo;
    logic [VAL_W-1:0]     r_c0_hi;
    logic [VAL_W-1:0]     r_r1;
    logic [VAL_W-1:0]     r_r2;
    logic                 r_oor;
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_out_data;
    logic                 r_out_oor;

    // Sequencer outputs.
    logic                 w_rd_en;
    logic                 w_rd_col1;
    logic                 w_ld_c0;
    logic                 w_ld_r1;
    logic                 w_ld_r2;
    logic                 w_fin_load;
    logic                 w_blend_en;
    logic [1:0]           w_blend_sel;

    // Bank addressing: rows xi and xi+1 always fall in different banks.
    logic [ROW_W-1:0]     w_xlo, w_xhi, w_row_even, w_row_odd;
    logic [COL_W-1:0]     w_ylo, w_yhi, w_rcol;
    logic [ROW_W-1:0]     w_wrow;
    logic [COL_W-1:0]     w_wcol;
    logic [ADDR_W-1:0]    w_waddr;
    logic                 w_we_even, w_we_odd;
    logic [VAL_W-1:0]     w_rd_even, w_rd_odd, w_rd_lo, w_rd_hi;

    assign w_xlo      = ROW_W'(r_xi);
    assign w_xhi      = w_xlo + ROW_W'(1);
    assign w_row_even = w_xlo[0] ? w_xhi : w_xlo;
    assign w_row_odd  = w_xlo[0] ? w_xlo : w_xhi;
    assign w_ylo      = COL_W'(r_yi);
    assign w_yhi      = w_ylo + COL_W'(1);
    assign w_rcol     = w_rd_col1 ? w_yhi : w_ylo;
    assign w_rd_lo    = w_xlo[0] ? w_rd_odd : w_rd_even;
    assign w_rd_hi    = w_xlo[0] ? w_rd_even : w_rd_odd;

    assign w_wrow     = ROW_W'(w_cell_row);
    assign w_wcol     = COL_W'(w_cell_col);
    assign w_waddr    = {w_wrow[ROW_W-1:1], w_wcol};
    assign w_we_even  = w_accept && (s_axis_tuser == REQ_WRITE) && w_wr_ok && !w_wrow[0];
    assign w_we_odd   = w_accept && (s_axis_tuser == REQ_WRITE) && w_wr_ok && w_wrow[0];

    bgs_bank #(
        .ADDR_W (ADDR_W)
    ) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (w_we_even),
        .i_waddr (w_waddr),
        .i_wdata (w_cell_value),
        .i_re    (w_rd_en),
        .i_raddr ({w_row_even[ROW_W-1:1], w_rcol}),
        .o_rdata (w_rd_even)
    );

    bgs_bank #(
        .ADDR_W (ADDR_W)
    ) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (w_we_odd),
        .i_waddr (w_waddr),
        .i_wdata (w_cell_value),
        .i_re    (w_rd_en),
        .i_raddr ({w_row_odd[ROW_W-1:1], w_rcol}),
        .o_rdata (w_rd_odd)
    );

    // Shared blend unit operands.
    logic signed [VAL_W-1:0] w_ba, w_bb;
    logic [FRAC_BITS-1:0]    w_bf;
    logic signed [SUM_W-1:0] w_blend;

    always_comb begin
        case (w_blend_sel)
            BLEND_ROW_LO: begin
                w_ba = $signed(r_c0_lo);
                w_bb = $signed(w_rd_lo);
                w_bf = r_fy;
            end
            BLEND_ROW_HI: begin
                w_ba = $signed(r_c0_hi);
                w_bb = $signed(w_rd_hi);
                w_bf = r_fy;
            end
            default: begin
                w_ba = $signed(r_r1);
                w_bb = $signed(r_r2);
                w_bf = r_fx;
            end
        endcase
    end

    bgs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_en    (w_blend_en),
        .i_a     (w_ba),
        .i_b     (w_bb),
        .i_f     (w_bf),
        .o_value (w_blend)
    );

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_rd_col1     = 1'b0;
        w_ld_c0       = 1'b0;
        w_ld_r1       = 1'b0;
        w_ld_r2       = 1'b0;
        w_fin_load    = 1'b0;
        w_blend_en    = 1'b0;
        w_blend_sel   = BLEND_ROW_LO;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == REQ_SAMPLE)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                if (r_oor) begin
                    n_state = S_FIN;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                w_rd_en   = 1'b1;
                w_rd_col1 = 1'b1;
                w_ld_c0   = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                w_blend_en  = 1'b1;
                w_blend_sel = BLEND_ROW_LO;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                w_blend_en  = 1'b1;
                w_blend_sel = BLEND_ROW_HI;
                w_ld_r1     = 1'b1;
                n_state     = S_ADD2;
            end
            S_ADD2: begin
                w_ld_r2 = 1'b1;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                w_blend_en  = 1'b1;
                w_blend_sel = BLEND_FINAL;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_fin_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == REQ_SAMPLE)) begin
            r_xi  <= INT_W'(w_pos_x >> FRAC_BITS);
            r_yi  <= INT_W'(w_pos_y >> FRAC_BITS);
            r_fx  <= FRAC_BITS'(w_pos_x);
            r_fy  <= FRAC_BITS'(w_pos_y);
            r_oor <= (32'(INT_W'(w_pos_x >> FRAC_BITS)) + 32'd1 >= 32'(GRID_ROWS))
                  || (32'(INT_W'(w_pos_y >> FRAC_BITS)) + 32'd1 >= 32'(GRID_COLS));
        end
        if (w_ld_c0) begin
            r_c0_lo <= w_rd_lo;
            r_c0_hi <= w_rd_hi;
        end
        // A blend of two 32-bit values with weights summing to one stays in range.
        if (w_ld_r1) begin
            r_r1 <= w_blend[VAL_W-1:0];
        end
        if (w_ld_r2) begin
            r_r2 <= w_blend[VAL_W-1:0];
        end
        if (w_fin_load) begin
            r_out_data <= r_oor ? '0 : sat_val(w_blend);
            r_out_oor  <= r_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_oor;

endmodule

[sv/bgs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_checker
// Port-level checks of the bilinear grid sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bgs_checker
    import bgs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tuser
);

    // A stalled result keeps its value and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An out-of-range sample always reports zero.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-range result is not zero");

    // No result is offered straight after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A sample request occupies the block for the following cycles.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_SAMPLE) |=> !s_axis_tready)
        else $error("request taken during a sample");

    // A cell write completes in its accept cycle.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_WRITE) |=> s_axis_tready)
        else $error("write request stalled the channel");

endmodule

bind bilinear_grid_sample bgs_checker u_bgs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/grid_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_sample_checker
// Scoreboard for the bilinear grid sampler.
// ----------------------------------------------------------------------------
// Watches both stream channels at the rising clock edge. An accepted cell
// write updates a private copy of the grid. An accepted sample is blended
// against that copy and queued. Every result leaving the block is compared,
// field by field, with the oldest queued sample.
// ----------------------------------------------------------------------------
module grid_sample_checker
    import bgs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tuser,
    output int                     o_mismatches,
    output int                     o_outstanding,
    output int                     o_samples_checked,
    output int                     o_oor_checked
);

    localparam int     ROWS     = DEF_GRID_ROWS;
    localparam int     COLS     = DEF_GRID_COLS;
    localparam int     FRAC     = DEF_FRAC_BITS;
    localparam longint FRAC_ONE = longint'(1) << FRAC;
    localparam longint HALF_LSB = longint'(1) << (FRAC - 1);
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint VAL_MIN  = -VAL_MAX - 1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             oor;
    } t_sample_result;

    logic signed [VAL_W-1:0] grid_copy [ROWS*COLS];
    t_sample_result          pending_samples [$];

    int mismatch_count = 0;
    int checked_count  = 0;
    int oor_count      = 0;

    assign o_mismatches      = mismatch_count;
    assign o_outstanding     = pending_samples.size();
    assign o_samples_checked = checked_count;
    assign o_oor_checked     = oor_count;

    // Weighted blend of two values, rounded to nearest with ties upwards.
    function automatic longint blend_pair(longint near_v, longint far_v, longint frac);
        return (near_v * (FRAC_ONE - frac) + far_v * frac + HALF_LSB) >>> FRAC;
    endfunction

    function automatic t_sample_result predict_sample(logic [POS_W-1:0] pos_row,
                                                      logic [POS_W-1:0] pos_col);
        int unsigned    base_r;
        int unsigned    base_c;
        longint         frac_r;
        longint         frac_c;
        longint         upper;
        longint         lower;
        longint         blended;
        t_sample_result res;
        base_r = pos_row >> FRAC;
        base_c = pos_col >> FRAC;
        frac_r = pos_row[FRAC-1:0];
        frac_c = pos_col[FRAC-1:0];
        res.value = '0;
        res.oor   = 1'b1;
        if (base_r + 1 >= ROWS || base_c + 1 >= COLS) begin
            return res;
        end
        upper = blend_pair(grid_copy[base_r*COLS + base_c],
                           grid_copy[base_r*COLS + base_c + 1], frac_c);
        lower = blend_pair(grid_copy[(base_r+1)*COLS + base_c],
                           grid_copy[(base_r+1)*COLS + base_c + 1], frac_c);
        blended = blend_pair(upper, lower, frac_r);
        if (blended > VAL_MAX) begin
            blended = VAL_MAX;
        end
        if (blended < VAL_MIN) begin
            blended = VAL_MIN;
        end
        res.value = blended[VAL_W-1:0];
        res.oor   = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sample_result want;
        int unsigned    row;
        int unsigned    col;
        if (i_rst_n) begin
            // Results are retired first; a sample accepted on this edge
            // cannot have produced a result yet.
            if (i_m_tvalid && i_m_tready) begin
                if (pending_samples.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected result value %h oor %b", $realtime,
                                 i_m_tdata, i_m_tuser);
                    end
                end else begin
                    want = pending_samples.pop_front();
                    checked_count++;
                    if (want.oor) begin
                        oor_count++;
                    end
                    if (i_m_tdata !== want.value || i_m_tuser !== want.oor) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: sample mismatch: value %h (want %h) oor %b (want %b)",
                                     $realtime, i_m_tdata, want.value, i_m_tuser, want.oor);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_WRITE) begin
                    row = i_s_tdata[ROW_LSB +: IDX_W];
                    col = i_s_tdata[COL_LSB +: IDX_W];
                    if (row < ROWS && col < COLS) begin
                        grid_copy[row*COLS + col] = i_s_tdata[VAL_LSB +: VAL_W];
                    end
                end else begin
                    pending_samples.push_back(predict_sample(i_s_tdata[POSX_LSB +: POS_W],
                                                             i_s_tdata[POSY_LSB +: POS_W]));
                end
            end
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bilinear grid sampler.
// ----------------------------------------------------------------------------
// A short directed part hits extreme cell values, zero and full fractions,
// rounding ties and positions on the last row and column. The random part
// mostly writes 2x2 patches and samples inside them, mixed with stray writes
// and samples that leave the grid. Both channels idle in random bursts and
// the output is held off once for a long stretch. A cell is never sampled
// before it has been written.
// ----------------------------------------------------------------------------
module testbench;
    import bgs_pkg::*;

    localparam int TOTAL_REQUESTS = 1450;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LAST_ROW       = DEF_GRID_ROWS - 1;
    localparam int LAST_COL       = DEF_GRID_COLS - 1;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   s_axis_tuser   = REQ_WRITE;
    logic                   m_axis_tready  = 1'b0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire                    m_axis_tuser;

    int mismatches;
    int outstanding;
    int samples_checked;
    int oor_checked;

    bit send_idle_en  = 1'b1;
    bit stall_en      = 1'b1;
    int hold_requests = 0;
    int holds_done    = 0;
    int requests_sent = 0;
    int writes_sent   = 0;
    int cycle_count   = 0;

    int unsigned patch_bases [$];

    always #6 clk = ~clk;

    bilinear_grid_sample dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    grid_sample_checker scoreboard (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tuser         (s_axis_tuser),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_m_tuser         (m_axis_tuser),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_samples_checked (samples_checked),
        .o_oor_checked     (oor_checked)
    );

    function automatic logic [VAL_W-1:0] rand_cell_value();
        case ($urandom_range(0, 7))
            0: begin
                return 32'h7FFF_FFFF;
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return $urandom_range(0, 255) - 128;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [DEF_FRAC_BITS-1:0] rand_frac();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return 16'h8000;
            end
            default: begin
                return DEF_FRAC_BITS'($urandom);
            end
        endcase
    endfunction

    // Offers one request and returns on the edge that accepts it.
    task automatic send_request(input logic kind, input logic [IN_TDATA_W-1:0] word);
        @(negedge clk);
        if (send_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        s_axis_tuser  = kind;
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic write_cell(input int unsigned row, input int unsigned col,
                              input logic [VAL_W-1:0] value);
        logic [IN_TDATA_W-1:0] word;
        word = IN_TDATA_W'({$urandom, $urandom, $urandom});
        word[ROW_LSB +: IDX_W] = row[IDX_W-1:0];
        word[COL_LSB +: IDX_W] = col[IDX_W-1:0];
        word[VAL_LSB +: VAL_W] = value;
        send_request(REQ_WRITE, word);
        writes_sent++;
    endtask

    task automatic sample_at(input int unsigned row, input int unsigned col,
                             input logic [DEF_FRAC_BITS-1:0] frac_r,
                             input logic [DEF_FRAC_BITS-1:0] frac_c);
        logic [IN_TDATA_W-1:0] word;
        word = IN_TDATA_W'({$urandom, $urandom, $urandom});
        word[POSX_LSB +: POS_W] = {row[IDX_W-1:0], frac_r};
        word[POSY_LSB +: POS_W] = {col[IDX_W-1:0], frac_c};
        send_request(REQ_SAMPLE, word);
    endtask

    // A 2x2 patch makes every position between its cells safe to sample.
    task automatic write_patch(input int unsigned row, input int unsigned col,
                               input logic [VAL_W-1:0] v00, input logic [VAL_W-1:0] v01,
                               input logic [VAL_W-1:0] v10, input logic [VAL_W-1:0] v11);
        write_cell(row, col, v00);
        write_cell(row, col + 1, v01);
        write_cell(row + 1, col, v10);
        write_cell(row + 1, col + 1, v11);
        patch_bases.push_back(row * DEF_GRID_COLS + col);
    endtask

    // Output side: random stalls, plus one long hold-off when asked for.
    initial begin
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_done++;
            end else if (stall_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, outstanding);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned pick;
        int unsigned base;
        int unsigned row;
        int unsigned col;
        bit          hold_issued;
        hold_issued = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        write_patch(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(0, 0, 16'h0000, 16'h0000);
        sample_at(0, 0, 16'hFFFF, 16'hFFFF);
        write_patch(LAST_ROW - 1, LAST_COL - 1, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0000_0000);
        sample_at(LAST_ROW - 1, LAST_COL - 1, 16'h8000, 16'h8000);
        sample_at(LAST_ROW - 1, LAST_COL - 1, 16'hFFFF, 16'h0000);
        sample_at(LAST_ROW, 0, 16'h0000, 16'h0000);
        sample_at(0, LAST_COL, 16'h0000, 16'h0000);
        sample_at(LAST_ROW, LAST_COL, 16'hFFFF, 16'hFFFF);
        write_cell(0, 0, 32'h8000_0000);
        sample_at(0, 0, 16'h8000, 16'h8000);
        sample_at(0, 0, 16'h0001, 16'hFFFF);
        write_cell(1, 1, 32'hFFFF_FFFF);
        write_cell(0, 1, 32'h0000_0000);
        sample_at(0, 0, 16'h8000, 16'h8000);

        // Random part: mostly patches sampled in place.
        while (requests_sent < TOTAL_REQUESTS) begin
            send_idle_en = requests_sent < 1200 &&
                           !(requests_sent >= 700 && requests_sent < 850);
            stall_en     = send_idle_en;
            if (!hold_issued && requests_sent >= 450) begin
                hold_requests++;
                hold_issued = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                row = $urandom_range(0, LAST_ROW - 1);
                col = $urandom_range(0, LAST_COL - 1);
                write_patch(row, col, rand_cell_value(), rand_cell_value(),
                            rand_cell_value(), rand_cell_value());
                repeat ($urandom_range(1, 3)) sample_at(row, col, rand_frac(), rand_frac());
            end else if (pick < 75) begin
                base = patch_bases[$urandom_range(0, patch_bases.size() - 1)];
                sample_at(base / DEF_GRID_COLS, base % DEF_GRID_COLS, rand_frac(), rand_frac());
            end else if (pick < 87) begin
                write_cell($urandom_range(0, LAST_ROW), $urandom_range(0, LAST_COL),
                           rand_cell_value());
            end else begin
                // Neighbours beyond the last row, the last column, or both.
                case ($urandom_range(0, 2))
                    0: begin
                        sample_at(LAST_ROW, $urandom_range(0, LAST_COL), rand_frac(), rand_frac());
                    end
                    1: begin
                        sample_at($urandom_range(0, LAST_ROW), LAST_COL, rand_frac(), rand_frac());
                    end
                    default: begin
                        sample_at(LAST_ROW, LAST_COL, rand_frac(), rand_frac());
                    end
                endcase
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d cell writes and %0d samples, %0d of them off the grid.",
                 requests_sent, writes_sent, samples_checked, oor_checked);
        $display("Both channels idled at random; the output was held off once for %0d cycles.",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
